### hdl/rtbm_pkg.sv
// Shared widths, reset values, register indexes and helpers of the RGBA to Bayer mosaic.
package rtbm_pkg;

	localparam int BYTE_W     = 8;
	localparam int SAMPLE_W   = 10;
	localparam int ADDR_W     = 23;
	localparam int CFG_W      = 13;
	localparam int CFG_IDX_W  = 4;

	localparam int DEF_MAX_WIDTH    = 4096;
	localparam int DEF_MAX_HEIGHT   = 4096;
	localparam int DEF_STRIDE_ALIGN = 16;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

	// Register indexes of the configuration channel.
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

	// 8-bit to 10-bit expansion: (SCALE_RND + v * SCALE_MUL) >> SCALE_SHIFT.
	localparam int SCALE_MUL_W = 15;
	localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = SCALE_MUL_W'(16410);
	localparam int SCALE_PROD_W = BYTE_W + SCALE_MUL_W;
	localparam logic [SCALE_PROD_W-1:0] SCALE_RND = SCALE_PROD_W'(8);
	localparam int SCALE_SHIFT = 12;

	// Cycles the frame geometry needs to settle after a register write.
	localparam int SETTLE_W = 2;
	localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = SETTLE_W'(2);

	// Largest even size that a 13-bit register can reach after clamping to maxv.
	function automatic int eff_dim(input int maxv);
		int top_even;
		top_even = (1 << CFG_W) - 2;
		if (maxv > top_even) begin
			return top_even;
		end
		return maxv & ~1;
	endfunction

	typedef struct packed {
		logic [ADDR_W-1:0]   word_address;
		logic [SAMPLE_W-1:0] low_sample;
		logic [SAMPLE_W-1:0] high_sample;
		logic                last_word;
		logic                size_error;
	} word_t;

endpackage

### hdl/rtbm_if.sv
// Channel interfaces: pixel pairs in, Bayer words out, and register writes.
interface rtbm_pair_if;
	import rtbm_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] first_red;
	logic [BYTE_W-1:0] first_green;
	logic [BYTE_W-1:0] second_green;
	logic [BYTE_W-1:0] second_blue;
	modport source (output valid, first_red, first_green, second_green, second_blue,
		input ready);
	modport sink (input valid, first_red, first_green, second_green, second_blue,
		output ready);
endinterface

interface rtbm_word_if;
	import rtbm_pkg::*;
	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   word_address;
	logic [SAMPLE_W-1:0] low_sample;
	logic [SAMPLE_W-1:0] high_sample;
	logic                last_word;
	logic                size_error;
	modport source (output valid, word_address, low_sample, high_sample, last_word,
		size_error, input ready);
	modport sink (input valid, word_address, low_sample, high_sample, last_word,
		size_error, output ready);
endinterface

interface rtbm_cfg_if;
	import rtbm_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hdl/rgba_to_bayer_raw10_mosaic.sv
// Top level of the RGBA to RGGB Bayer RAW10 mosaic with its frame counters.
//
// The block takes an RGBA image in raster order, one pixel pair per transfer, and
// returns one output word per transfer: two 10-bit Bayer samples and the word's
// index in the output buffer. Even rows carry the left pixel's red and the right
// pixel's green, odd rows the left pixel's green and the right pixel's blue. Each
// byte v becomes (8 + v*16410) >> 12. Rows are laid out with a stride of the width
// rounded up to STRIDE_ALIGN pixels; padding words are never produced. An odd or
// zero width or height gives words with size_error set, all other fields zero, and
// the position does not advance. Widths and heights above MAX_WIDTH and MAX_HEIGHT
// are clamped. One pixel pair is accepted every cycle unless the two-entry output
// buffer is full or the input is paused: two sample lanes work side by side on the
// pair, the frame counters advance in that same cycle and the word is registered in
// the buffer, which lets a pair be taken while the previous word waits. After reset
// and after every register write the input pauses while the row geometry (pairs,
// clamped height and padded stride) is recomputed through its two register stages.
module rgba_to_bayer_raw10_mosaic #(
	parameter int MAX_WIDTH    = rtbm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = rtbm_pkg::DEF_MAX_HEIGHT,
	parameter int STRIDE_ALIGN = rtbm_pkg::DEF_STRIDE_ALIGN
) (
	input  logic        clk,
	input  logic        arst_n,
	rtbm_pair_if.sink   pixels,
	rtbm_word_if.source words,
	rtbm_cfg_if.sink    cfg
);
	import rtbm_pkg::*;

	localparam int EW     = eff_dim(MAX_WIDTH);
	localparam int EH     = eff_dim(MAX_HEIGHT);
	localparam int PAIR_W = $clog2(EW / 2 + 1);
	localparam int COL_W  = $clog2(EW / 2);
	localparam int H_W    = $clog2(EH + 1);
	localparam int ROW_W  = $clog2(EH);

	// Configuration registers.
	logic [CFG_W-1:0]    width_q;
	logic [CFG_W-1:0]    height_q;
	logic [SETTLE_W-1:0] settle_q;

	// Frame position.
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] base_q;

	// Geometry derived from the registers.
	logic              geo_err;
	logic [PAIR_W-1:0] geo_pairs;
	logic [H_W-1:0]    geo_height;
	logic [ADDR_W-1:0] geo_stride;

	logic              buf_ready;
	logic              fire;
	logic              outside;
	logic [COL_W-1:0]  col_cur;
	logic [ROW_W-1:0]  row_cur;
	logic [ADDR_W-1:0] base_cur;
	logic [PAIR_W-1:0] col_inc;
	logic [H_W-1:0]    row_inc;
	logic              last_col;
	logic              last_row;
	logic [SAMPLE_W-1:0] low_lane;
	logic [SAMPLE_W-1:0] high_lane;
	word_t             word_c;
	word_t             word_out;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			settle_q <= SETTLE_CYCLES;
		end else if (cfg.valid && cfg.ready) begin
			settle_q <= SETTLE_CYCLES;
			unique case (cfg.index)
				REG_WIDTH: begin
					width_q <= cfg.data;
				end
				REG_HEIGHT: begin
					height_q <= cfg.data;
				end
				default: begin
				end
			endcase
		end else if (settle_q != '0) begin
			settle_q <= settle_q - SETTLE_W'(1);
		end
	end

	rtbm_geom #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.STRIDE_ALIGN (STRIDE_ALIGN)
	) u_geom (
		.clk          (clk),
		.image_width  (width_q),
		.image_height (height_q),
		.size_err     (geo_err),
		.pairs        (geo_pairs),
		.height       (geo_height),
		.stride       (geo_stride)
	);

	assign pixels.ready = buf_ready && (settle_q == '0);
	assign fire         = pixels.valid && pixels.ready;

	// If the frame shrank under the current position, the frame restarts at the origin.
	always_comb begin
		outside  = (PAIR_W'(col_q) >= geo_pairs) || (H_W'(row_q) >= geo_height);
		col_cur  = outside ? '0 : col_q;
		row_cur  = outside ? '0 : row_q;
		base_cur = outside ? '0 : base_q;
		col_inc  = PAIR_W'(col_cur) + PAIR_W'(1);
		row_inc  = H_W'(row_cur) + H_W'(1);
		last_col = (col_inc == geo_pairs);
		last_row = (row_inc == geo_height);
	end

	// Left lane: red on even rows, green on odd rows.
	rtbm_lane u_lane_low (
		.even_byte (pixels.first_red),
		.odd_byte  (pixels.first_green),
		.odd_row   (row_cur[0]),
		.sample    (low_lane)
	);

	// Right lane: green on even rows, blue on odd rows.
	rtbm_lane u_lane_high (
		.even_byte (pixels.second_green),
		.odd_byte  (pixels.second_blue),
		.odd_row   (row_cur[0]),
		.sample    (high_lane)
	);

	// Merge the lanes with the address and frame flags into one output word.
	always_comb begin
		if (geo_err) begin
			word_c = '0;
			word_c.size_error = 1'b1;
		end else begin
			word_c.word_address = base_cur + ADDR_W'(col_cur);
			word_c.low_sample   = low_lane;
			word_c.high_sample  = high_lane;
			word_c.last_word    = last_col && last_row;
			word_c.size_error   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			base_q <= '0;
		end else if (fire && !geo_err) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q  <= '0;
					base_q <= '0;
				end else begin
					row_q  <= ROW_W'(row_inc);
					base_q <= base_cur + geo_stride;
				end
			end else begin
				col_q  <= COL_W'(col_inc);
				row_q  <= row_cur;
				base_q <= base_cur;
			end
		end
	end

	rtbm_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fire),
		.in_ready  (buf_ready),
		.in_word   (word_c),
		.out_valid (words.valid),
		.out_ready (words.ready),
		.out_word  (word_out)
	);

	assign words.word_address = word_out.word_address;
	assign words.low_sample   = word_out.low_sample;
	assign words.high_sample  = word_out.high_sample;
	assign words.last_word    = word_out.last_word;
	assign words.size_error   = word_out.size_error;
endmodule

### hdl/rtbm_lane.sv
// One sample lane: picks the byte for the row's color and expands it to 10 bits.
module rtbm_lane (
	input  logic [rtbm_pkg::BYTE_W-1:0]   even_byte,
	input  logic [rtbm_pkg::BYTE_W-1:0]   odd_byte,
	input  logic                          odd_row,
	output logic [rtbm_pkg::SAMPLE_W-1:0] sample
);
	import rtbm_pkg::*;

	logic [BYTE_W-1:0]       pick;
	logic [SCALE_PROD_W-1:0] prod;

	always_comb begin
		pick   = odd_row ? odd_byte : even_byte;
		prod   = SCALE_PROD_W'(pick) * SCALE_PROD_W'(SCALE_MUL) + SCALE_RND;
		sample = prod[SCALE_SHIFT +: SAMPLE_W];
	end
endmodule

### hdl/rtbm_geom.sv
// Frame geometry: size check, clamping, pairs per row and padded row stride.
module rtbm_geom #(
	parameter int MAX_WIDTH    = rtbm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = rtbm_pkg::DEF_MAX_HEIGHT,
	parameter int STRIDE_ALIGN = rtbm_pkg::DEF_STRIDE_ALIGN,
	localparam int EW     = rtbm_pkg::eff_dim(MAX_WIDTH),
	localparam int EH     = rtbm_pkg::eff_dim(MAX_HEIGHT),
	localparam int PAIR_W = $clog2(EW / 2 + 1),
	localparam int H_W    = $clog2(EH + 1)
) (
	input  logic                          clk,
	input  logic [rtbm_pkg::CFG_W-1:0]    image_width,
	input  logic [rtbm_pkg::CFG_W-1:0]    image_height,
	output logic                          size_err,
	output logic [PAIR_W-1:0]             pairs,
	output logic [H_W-1:0]                height,
	output logic [rtbm_pkg::ADDR_W-1:0]   stride
);
	import rtbm_pkg::*;

	localparam int WC_W   = $clog2(EW + 1);
	localparam int ALIGN  = (STRIDE_ALIGN < 1) ? 1 : STRIDE_ALIGN;
	localparam int AW     = $clog2(ALIGN + 1);
	// Reciprocal of the alignment, exact for every clamped width.
	localparam int RSH    = WC_W + $clog2(ALIGN) + 1;
	localparam int RCP_W  = RSH + 1;
	localparam logic [RCP_W-1:0] RCP = RCP_W'((2 ** RSH) / ALIGN + 1);
	localparam int PROD_W = WC_W + RCP_W;
	localparam int QA_W   = WC_W + AW;

	logic              err_c;
	logic [WC_W-1:0]   wc_c;
	logic [H_W-1:0]    hc_c;
	logic [PROD_W-1:0] prod_c;

	logic              err_s1;
	logic [WC_W-1:0]   wc_s1;
	logic [H_W-1:0]    hc_s1;
	logic [WC_W-1:0]   q_s1;

	logic [QA_W-1:0]   rem_c;
	logic [AW-1:0]     pad_c;

	always_comb begin
		wc_c = (int'(image_width) > MAX_WIDTH) ? WC_W'(MAX_WIDTH & ~1) : WC_W'(image_width);
		hc_c = (int'(image_height) > MAX_HEIGHT) ? H_W'(MAX_HEIGHT & ~1) : H_W'(image_height);
		err_c = image_width[0] | image_height[0] | (wc_c == '0) | (hc_c == '0);
		prod_c = PROD_W'(wc_c) * PROD_W'(RCP);
	end

	always_ff @(posedge clk) begin
		err_s1 <= err_c;
		wc_s1  <= wc_c;
		hc_s1  <= hc_c;
		q_s1   <= WC_W'(prod_c >> RSH);
	end

	// Remainder of the width by the alignment, then the padding up to the next multiple.
	always_comb begin
		rem_c = QA_W'(wc_s1) - QA_W'(q_s1) * QA_W'(ALIGN);
		pad_c = (rem_c == '0) ? '0 : AW'(QA_W'(ALIGN) - rem_c);
	end

	always_ff @(posedge clk) begin
		size_err <= err_s1;
		pairs    <= PAIR_W'(wc_s1 >> 1);
		height   <= hc_s1;
		stride   <= ADDR_W'(wc_s1 >> 1) + ADDR_W'(pad_c >> 1);
	end
endmodule

### hdl/rtbm_skid.sv
// Two-entry output buffer that lets the input side take one more word while the output stalls.
module rtbm_skid (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rtbm_pkg::word_t in_word,
	output logic            out_valid,
	input  logic            out_ready,
	output rtbm_pkg::word_t out_word
);
	import rtbm_pkg::*;

	logic  main_valid_q;
	logic  skid_valid_q;
	word_t main_q;
	word_t skid_q;
	logic  fire;
	logic  drain;

	assign in_ready  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_word  = main_q;
	assign fire      = in_valid && in_ready;
	assign drain     = main_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (drain) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= fire;
			end
		end else if (fire) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (fire) begin
				main_q <= in_word;
			end
		end else if (fire) begin
			if (main_valid_q) begin
				skid_q <= in_word;
			end else begin
				main_q <= in_word;
			end
		end
	end
endmodule

### bench/rtbm_mosaic_checker.sv
`timescale 1ns / 1ps
// Checker for the RGBA to Bayer mosaic: predicts every output word and compares it.
module rtbm_mosaic_checker #(
	parameter int MAX_WIDTH    = rtbm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = rtbm_pkg::DEF_MAX_HEIGHT,
	parameter int STRIDE_ALIGN = rtbm_pkg::DEF_STRIDE_ALIGN
) (
	input  logic clk,
	input  logic arst_n,
	rtbm_pair_if pixels,
	rtbm_word_if words,
	rtbm_cfg_if  cfg,
	output int   mismatch_count,
	output int   words_owed
);
	import rtbm_pkg::*;

	localparam int EXPAND_MUL   = 16410;
	localparam int EXPAND_RND   = 8;
	localparam int EXPAND_SHIFT = 12;

	logic [CFG_W-1:0]  width_reg;
	logic [CFG_W-1:0]  height_reg;
	int unsigned       pair_col;
	int unsigned       row_idx;
	logic [ADDR_W-1:0] row_base;
	int                fails;
	word_t             bayer_words[$];

	function automatic logic [SAMPLE_W-1:0] expand_byte(input logic [BYTE_W-1:0] v);
		int unsigned prod;
		prod = EXPAND_RND + 32'(v) * EXPAND_MUL;
		return SAMPLE_W'(prod >> EXPAND_SHIFT);
	endfunction

	// Works out the word for one pixel pair and, if the size is usable, moves the frame position on.
	function automatic word_t mosaic_word(input logic [BYTE_W-1:0] red0, green0, green1,
		blue1);
		word_t       w;
		int unsigned span;
		int unsigned rows;
		int unsigned pairs;
		int unsigned padded;
		w = '0;
		if (width_reg[0] || height_reg[0] || width_reg == '0 || height_reg == '0) begin
			w.size_error = 1'b1;
			return w;
		end
		span = (32'(width_reg) > MAX_WIDTH) ? (MAX_WIDTH & ~1) : 32'(width_reg);
		rows = (32'(height_reg) > MAX_HEIGHT) ? (MAX_HEIGHT & ~1) : 32'(height_reg);
		if (span == 0 || rows == 0) begin
			w.size_error = 1'b1;
			return w;
		end
		pairs  = span / 2;
		padded = (span + STRIDE_ALIGN - 1) / STRIDE_ALIGN * STRIDE_ALIGN;
		// A size change can leave the position outside the frame: start over.
		if (pair_col >= pairs || row_idx >= rows) begin
			pair_col = 0;
			row_idx  = 0;
			row_base = '0;
		end
		if (row_idx[0] == 1'b0) begin
			w.low_sample  = expand_byte(red0);
			w.high_sample = expand_byte(green1);
		end else begin
			w.low_sample  = expand_byte(green0);
			w.high_sample = expand_byte(blue1);
		end
		w.last_word    = (row_idx == rows - 1) && (pair_col == pairs - 1);
		w.word_address = ADDR_W'(32'(row_base) + pair_col);
		pair_col++;
		if (pair_col >= pairs) begin
			pair_col = 0;
			row_idx++;
			row_base = ADDR_W'(32'(row_base) + pairs + (padded - span) / 2);
			if (row_idx >= rows) begin
				row_idx  = 0;
				row_base = '0;
			end
		end
		return w;
	endfunction

	task automatic check_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", field, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		word_t want;
		if (!arst_n) begin
			width_reg  = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			pair_col   = 0;
			row_idx    = 0;
			row_base   = '0;
			fails      = 0;
			bayer_words.delete();
			mismatch_count <= 0;
			words_owed     <= 0;
		end else begin
			// Words go first: a word leaving on this edge belongs to an older pair.
			if (words.valid && words.ready) begin
				if (bayer_words.size() == 0) begin
					$error("word at address %0d with no pixel pair pending",
						words.word_address);
					fails++;
				end else begin
					want = bayer_words.pop_front();
					check_field("word_address", 32'(want.word_address),
						32'(words.word_address));
					check_field("low_sample", 32'(want.low_sample),
						32'(words.low_sample));
					check_field("high_sample", 32'(want.high_sample),
						32'(words.high_sample));
					check_field("last_word", 32'(want.last_word),
						32'(words.last_word));
					check_field("size_error", 32'(want.size_error),
						32'(words.size_error));
				end
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_WIDTH) begin
					width_reg = cfg.data;
				end else if (cfg.index == REG_HEIGHT) begin
					height_reg = cfg.data;
				end
			end
			if (pixels.valid && pixels.ready) begin
				bayer_words.push_back(mosaic_word(pixels.first_red, pixels.first_green,
					pixels.second_green, pixels.second_blue));
			end
			mismatch_count <= fails;
			words_owed     <= bayer_words.size();
		end
	end

endmodule

### bench/tb_rgba_to_bayer_raw10_mosaic.sv
`timescale 1ns / 1ps
// Testbench top for the RGBA to Bayer mosaic: clock, reset, stimulus and verdict.
module tb_rgba_to_bayer_raw10_mosaic;
	import rtbm_pkg::*;

	// Roughly how many pixel pairs the run sends before it winds down.
	localparam int PAIR_TARGET = 1900;
	// Cycles without any transfer on any channel before the run is declared hung.
	localparam int QUIET_LIMIT = 2000;
	// Cycles to keep watching after the last expected word, to catch stray words.
	localparam int DRAIN_CYCLES = 8;
	// A register index that the block does not implement; writes to it are dropped.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(2);

	logic             clk;
	logic             arst_n;
	logic             steady;
	int               mismatches;
	int               words_owed;
	int               pairs_sent;
	int               quiet_cycles;
	logic [CFG_W-1:0] cur_width;
	logic [CFG_W-1:0] cur_height;

	rtbm_pair_if pixels();
	rtbm_word_if words();
	rtbm_cfg_if  cfg();

	rgba_to_bayer_raw10_mosaic dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pixels(pixels),
		.words (words),
		.cfg   (cfg)
	);

	// The checker sits beside the block, predicts every word and counts mismatches.
	rtbm_mosaic_checker mosaic_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.pixels        (pixels),
		.words         (words),
		.cfg           (cfg),
		.mismatch_count(mismatches),
		.words_owed    (words_owed)
	);

	always #2 clk = ~clk;

	// The word sink stalls at random about seven percent of the time, except in the steady
	// stretch where it takes a word on every cycle.
	always @(posedge clk) begin
		words.ready <= steady || ($urandom_range(99) >= 7);
	end

	// Watchdog: any transfer on any channel counts as progress. A long silence
	// means the block has hung or lost a word.
	always @(posedge clk) begin
		if (!arst_n || (pixels.valid && pixels.ready) || (words.valid && words.ready)
			|| (cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Writes one register and keeps its valid high; the next pair that is offered
	// releases the channel, so back-to-back writes never drop valid in between.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		if (idx == REG_WIDTH) begin
			cur_width = value;
		end else if (idx == REG_HEIGHT) begin
			cur_height = value;
		end
	endtask

	// Offers one pixel pair, with an occasional random gap in front of it, and
	// returns once the pair has been taken. Valid stays high for the next pair.
	task automatic send_pair(input logic [BYTE_W-1:0] red0, green0, green1, blue1);
		// Any register write is complete by now, so the write channel goes quiet.
		cfg.valid <= 1'b0;
		while (!steady && $urandom_range(99) < 7) begin
			pixels.valid <= 1'b0;
			@(posedge clk);
		end
		pixels.valid        <= 1'b1;
		pixels.first_red    <= red0;
		pixels.first_green  <= green0;
		pixels.second_green <= green1;
		pixels.second_blue  <= blue1;
		@(posedge clk);
		while (!pixels.ready) @(posedge clk);
		pairs_sent++;
	endtask

	task automatic send_random_pairs(input int count);
		for (int k = 0; k < count; k++) begin
			send_pair(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
				BYTE_W'($urandom));
		end
	endtask

	// Stops the pixel stream and waits until every predicted word has come out,
	// so that the block is idle before the next register write.
	task automatic settle();
		pixels.valid <= 1'b0;
		@(posedge clk);
		while (words_owed != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [CFG_W-1:0] new_w;
		logic [CFG_W-1:0] new_h;
		int               frame;
		int               count;
		int               pick;
		int               phase;

		clk                 = 1'b0;
		arst_n              = 1'b0;
		steady              = 1'b0;
		pairs_sent          = 0;
		cur_width           = WIDTH_RESET;
		cur_height          = HEIGHT_RESET;
		pixels.valid        = 1'b0;
		pixels.first_red    = '0;
		pixels.first_green  = '0;
		pixels.second_green = '0;
		pixels.second_blue  = '0;
		cfg.valid           = 1'b0;
		cfg.index           = REG_WIDTH;
		cfg.data            = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// The reset geometry of 640 by 480: the first words of a large frame, with
		// all-zero, all-one and alternating bytes.
		send_pair(8'h00, 8'h00, 8'h00, 8'h00);
		send_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_pair(8'hAA, 8'h55, 8'hAA, 8'h55);
		settle();

		// Shrinking to 4 by 2 leaves the column outside the frame, so the frame
		// restarts. Four pairs then make one whole frame: an even row of red and
		// green, an odd row of green and blue on the padded stride, and the last word.
		write_reg(REG_WIDTH, CFG_W'(4));
		write_reg(REG_HEIGHT, CFG_W'(2));
		send_pair(8'h55, 8'hAA, 8'h55, 8'hAA);
		send_pair(8'hFF, 8'h00, 8'hFF, 8'h00);
		send_pair(8'h00, 8'hFF, 8'h00, 8'hFF);
		send_pair(8'h01, 8'h80, 8'h7F, 8'hFE);
		settle();

		// Unusable sizes: odd height, zero height, odd width at the top of the
		// register's range, and zero width. Each word is flagged and the position holds.
		write_reg(REG_HEIGHT, CFG_W'(7));
		send_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		settle();
		write_reg(REG_HEIGHT, CFG_W'(0));
		send_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		settle();
		write_reg(REG_HEIGHT, CFG_W'(2));
		write_reg(REG_WIDTH, CFG_W'(8191));
		send_pair(8'h80, 8'h80, 8'h80, 8'h80);
		settle();
		write_reg(REG_WIDTH, CFG_W'(0));
		send_pair(8'h80, 8'h80, 8'h80, 8'h80);
		settle();

		// Sizes past the maximum are clamped to it.
		write_reg(REG_WIDTH, CFG_W'(8190));
		write_reg(REG_HEIGHT, CFG_W'(8190));
		send_random_pairs(2);
		settle();

		// A write to an unimplemented register must leave the geometry alone.
		write_reg(REG_SPARE, CFG_W'(8191));
		send_random_pairs(1);
		settle();

		// Column outside a narrower frame, then row outside a shorter frame.
		write_reg(REG_WIDTH, CFG_W'(6));
		write_reg(REG_HEIGHT, CFG_W'(4));
		send_random_pairs(5);
		settle();
		write_reg(REG_WIDTH, CFG_W'(2));
		send_random_pairs(2);
		settle();
		write_reg(REG_HEIGHT, CFG_W'(2));
		send_random_pairs(2);
		settle();

		// Random phases. Most use small frames and run through whole frames and a
		// part of the next, so that row changes, padding and the last word come
		// often. A few use unusable sizes or very large frames. Some phases change
		// only one register, which may leave the position outside the new frame.
		phase = 0;
		while (pairs_sent < PAIR_TARGET) begin
			steady <= (phase >= 10 && phase < 18);
			pick = $urandom_range(99);
			if (pick < 6) begin
				new_w = ($urandom_range(1) == 0) ? CFG_W'(0) : CFG_W'($urandom_range(8191) | 1);
				write_reg(($urandom_range(1) == 0) ? REG_WIDTH : REG_HEIGHT, new_w);
				count = $urandom_range(1, 4);
			end else if (pick < 14) begin
				new_w = CFG_W'($urandom_range(1024, 8191)) & ~CFG_W'(1);
				new_h = CFG_W'($urandom_range(2, 8191)) & ~CFG_W'(1);
				write_reg(REG_WIDTH, new_w);
				write_reg(REG_HEIGHT, new_h);
				count = $urandom_range(16, 64);
			end else begin
				new_w = CFG_W'(2 * $urandom_range(1, 24));
				new_h = CFG_W'(2 * $urandom_range(1, 4));
				case ($urandom_range(2))
					0: begin
						write_reg(REG_WIDTH, new_w);
						write_reg(REG_HEIGHT, new_h);
					end
					1: begin
						write_reg(REG_WIDTH, new_w);
					end
					default: begin
						write_reg(REG_HEIGHT, new_h);
					end
				endcase
				// With only one register changed the other may still hold an
				// unusable or large size; then a short burst is enough.
				if (cur_width[0] || cur_height[0] || cur_width == '0 || cur_height == '0
					|| cur_width > 64 || cur_height > 8) begin
					count = $urandom_range(8, 40);
				end else begin
					frame = int'(cur_width) / 2 * int'(cur_height);
					count = frame * $urandom_range(1, 2) + $urandom_range(0, frame - 1);
					if (count > 160) begin
						count = 160;
					end
				end
			end
			send_random_pairs(count);
			settle();
			phase++;
		end

		steady <= 1'b0;
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
